/* hw/rtl/spbc_pkg.sv */
package spbc_pkg;

  // pair kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_SPH_SPH   = 2'd0,
    FUNC_SPH_PLANE = 2'd1,
    FUNC_BOX_SPH   = 2'd2
  } func_t;

  localparam int CFG_IDX_W  = 2;
  localparam int REST_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_REST_SPH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_BOX = 2'd1;

  localparam logic [REST_W-1:0] REST_SPH_RST = 8'd128;
  localparam logic [REST_W-1:0] REST_BOX_RST = 8'd192;

endpackage

/* hw/rtl/spbc_isqrt.sv */
module spbc_isqrt #(
  parameter int RTW = 34
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2*RTW-1:0]   rad,
  output logic [RTW-1:0]     root
);
  import spbc_pkg::*;

  localparam int REMW = RTW + 3;

  logic [REMW-1:0]    rem_r  [RTW];
  logic [RTW-1:0]     root_r [RTW];
  logic [2*RTW-1:0]   rad_r  [RTW];

  // one result bit per stage, digit recurrence on the remainder
  for (genvar i = 0; i < RTW; i++) begin : g_stage
    logic [REMW-1:0]  rem_in;
    logic [REMW-1:0]  rem_sh;
    logic [REMW-1:0]  trial;
    logic [RTW-1:0]   root_in;
    logic [2*RTW-1:0] rad_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], rad_in[2*RTW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[RTW-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[RTW-2:0], 1'b0};
        end
        rad_r[i] <= {rad_in[2*RTW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RTW-1];

endmodule

/* hw/rtl/spbc_div.sv */
module spbc_div #(
  parameter int NW  = 33,
  parameter int DNW = 34,
  parameter int QW  = 17
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DNW-1:0]  den,
  output logic [QW-1:0]   quo
);
  import spbc_pkg::*;

  localparam int RW = DNW + 1;

  logic [RW-1:0]  rem_r [QW];
  logic [QW-1:0]  q_r   [QW];
  logic [DNW-1:0] den_r [QW];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0]  rem_in;
    logic [QW-1:0]  q_in;
    logic [DNW-1:0] den_in;
    logic [RW-1:0]  dx;

    if (i == 0) begin : g_first
      assign rem_in = RW'(num);
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = {rem_r[i-1][RW-2:0], 1'b0};
      assign q_in   = q_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign dx = {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= dx) begin
          rem_r[i] <= rem_in - dx;
          q_r[i]   <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= rem_in;
          q_r[i]   <= {q_in[QW-2:0], 1'b0};
        end
        den_r[i] <= den_in;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

/* hw/rtl/sphere_plane_box_contact_test.sv */
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tuser: func; tdata: a, b, c, radius_a, value_b
// out_    | out | out_tvalid/tready  | tuser: colliding; tdata: normal, point, depths, restitution
// cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// One item per cycle while out_ accepts results. The square root takes
// WORD_BITS+2 stages (one root bit each) and the normal division FRAC_BITS+1 stages.
// rst_n clears the valid bits and resets the config registers; payload flops are not reset.
// The whole pipeline holds while a result sits unaccepted on out_.
module sphere_plane_box_contact_test #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                in_tvalid,
  output logic                in_tready,
  // func
  input  logic [1:0]          in_tuser,
  // a_x a_y a_z b_x b_y b_z c_x c_y c_z radius_a value_b, zero padded
  input  logic [((11*WORD_BITS-1+7)/8)*8-1:0] in_tdata,

  output logic                out_tvalid,
  input  logic                out_tready,
  // colliding
  output logic                out_tuser,
  // normal_x..z point_x..z depth_first depth_second restitution, zero padded
  output logic [((3*(FRAC_BITS+2)+5*WORD_BITS+8+7)/8)*8-1:0] out_tdata,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spbc_pkg::REST_W-1:0]    cfg_data
);
  import spbc_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NB   = F + 2;
  localparam int MW   = W + 1;
  localparam int SQW  = 2 * W + 2;
  localparam int RTW  = W + 2;
  localparam int XW   = 2 * W + 4;
  localparam int QW   = F + 1;
  localparam int OUTW = ((3 * NB + 5 * W + 8 + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]            func;
    logic [2:0][W-1:0]     a;
    logic [2:0][W-1:0]     b;
    logic [2:0][W-1:0]     q;
    logic [W-2:0]          r;
    logic [W-1:0]          vb;
    logic [2:0][MW-1:0]    dmag;
    logic [2:0]            dneg;
    logic [SQW-1:0]        dot;
    logic [RTW-1:0]        len;
    logic                  hit;
    logic [W-1:0]          dep1;
    logic [W-1:0]          dep2;
  } pay_t;

  function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction

  // configuration
  logic [REST_W-1:0] rest_sph_r, rest_box_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_sph_r <= REST_SPH_RST;
      rest_box_r <= REST_BOX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REST_SPH: rest_sph_r <= cfg_data;
        REG_REST_BOX: rest_box_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1: unpack, separation vector, closest box point
  pay_t st1_nxt, st1_r;
  logic v1_r;
  always_comb begin
    logic signed [W:0] ax, bx, cx, qx, dx;
    st1_nxt      = '0;
    st1_nxt.func = in_tuser;
    st1_nxt.r    = in_tdata[9*W +: W-1];
    st1_nxt.vb   = in_tdata[10*W-1 +: W];
    for (int i = 0; i < 3; i++) begin
      st1_nxt.a[i] = in_tdata[i*W +: W];
      st1_nxt.b[i] = in_tdata[(3+i)*W +: W];
      ax = $signed({st1_nxt.a[i][W-1], st1_nxt.a[i]});
      bx = $signed({st1_nxt.b[i][W-1], st1_nxt.b[i]});
      cx = $signed({in_tdata[(7+i)*W-1], in_tdata[(6+i)*W +: W]});
      qx = (ax < bx) ? bx : ((ax > cx) ? cx : ax);
      st1_nxt.q[i] = qx[W-1:0];
      dx = (in_tuser == FUNC_BOX_SPH) ? (ax - qx) : (bx - ax);
      st1_nxt.dneg[i] = dx[W];
      st1_nxt.dmag[i] = dx[W] ? MW'(-dx) : MW'(dx);
    end
  end

  // stage 2: squares and dot products
  pay_t st2_r;
  logic v2_r;
  logic [2:0][SQW-1:0] sq_r;
  logic [2:0][2*W-1:0] dp_r;

  // stage 3: sums
  pay_t st3_nxt, st3_r;
  logic v3_r;
  logic [SQW-1:0] ssum_r;

  always_comb begin
    st3_nxt     = st2_r;
    st3_nxt.dot = SQW'($signed(dp_r[0])) + SQW'($signed(dp_r[1]))
                + SQW'($signed(dp_r[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st1_nxt;
      st2_r <= st1_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= st1_r.dmag[i] * st1_r.dmag[i];
        dp_r[i] <= $signed(st1_r.a[i]) * $signed(st1_r.b[i]);
      end
      st3_r     <= st3_nxt;
      ssum_r    <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // square root, payload rides alongside
  logic [RTW-1:0] root;
  spbc_isqrt #(.RTW(RTW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({2'b00, ssum_r}),
    .root (root)
  );

  pay_t dl_sq_r [RTW];
  logic [RTW-1:0] vsq_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dl_sq_r[0] <= st3_r;
      for (int k = 1; k < RTW; k++) dl_sq_r[k] <= dl_sq_r[k-1];
    end
  end

  // stage 4: contact decision and depths
  pay_t st4_nxt, st4_r;
  logic v4_r;
  always_comb begin
    logic signed [XW-1:0] lx, rx, vbx, rsum, perp;
    st4_nxt     = dl_sq_r[RTW-1];
    st4_nxt.len = root;
    lx   = XW'($signed({1'b0, root}));
    rx   = XW'($signed({1'b0, st4_nxt.r}));
    vbx  = XW'($signed(st4_nxt.vb));
    rsum = rx + vbx;
    perp = XW'($signed(st4_nxt.dot) >>> F) - vbx;
    st4_nxt.hit  = 1'b0;
    st4_nxt.dep1 = '0;
    st4_nxt.dep2 = '0;
    case (st4_nxt.func)
      FUNC_SPH_SPH: begin
        st4_nxt.hit  = (lx <= rsum);
        st4_nxt.dep1 = sat_w(lx - rsum);
        st4_nxt.dep2 = sat_w(rsum - lx);
      end
      FUNC_SPH_PLANE: begin
        st4_nxt.hit  = (perp <= rx);
        st4_nxt.dep1 = sat_w(rx - perp);
      end
      FUNC_BOX_SPH: begin
        st4_nxt.hit  = (lx <= rx);
        st4_nxt.dep2 = sat_w(rx - lx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) st4_r <= st4_nxt;
  end

  // normal components: three dividers in lockstep
  logic [2:0][QW-1:0] quo;
  for (genvar i = 0; i < 3; i++) begin : g_div
    spbc_div #(.NW(MW), .DNW(RTW), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (st4_r.dmag[i]),
      .den (st4_r.len),
      .quo (quo[i])
    );
  end

  pay_t dl_dv_r [QW];
  logic [QW-1:0] vdv_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dl_dv_r[0] <= st4_r;
      for (int k = 1; k < QW; k++) dl_dv_r[k] <= dl_dv_r[k-1];
    end
  end

  // stage 5: signed normal, offset product
  pay_t st5_r;
  logic v5_r;
  logic [2:0][NB-1:0]  nrm_nxt, nrm_r;
  logic [2:0][2*W-1:0] prod_r;
  logic [2:0][W-1:0]   mop;
  always_comb begin
    logic signed [XW-1:0] bx, one;
    logic [NB-1:0] qn;
    one = XW'(1) <<< F;
    for (int i = 0; i < 3; i++) begin
      bx = XW'($signed(dl_dv_r[QW-1].b[i]));
      qn = {1'b0, quo[i]};
      if (dl_dv_r[QW-1].func == FUNC_SPH_PLANE) begin
        if (bx > one) nrm_nxt[i] = one[NB-1:0];
        else if (bx < -one) nrm_nxt[i] = NB'(-one);
        else nrm_nxt[i] = bx[NB-1:0];
        mop[i] = dl_dv_r[QW-1].b[i];
      end else begin
        if (dl_dv_r[QW-1].len == '0) nrm_nxt[i] = '0;
        else nrm_nxt[i] = dl_dv_r[QW-1].dneg[i] ? -qn : qn;
        mop[i] = W'($signed(nrm_nxt[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st5_r <= dl_dv_r[QW-1];
      nrm_r <= nrm_nxt;
      for (int i = 0; i < 3; i++)
        prod_r[i] <= $signed(mop[i]) * $signed({1'b0, dl_dv_r[QW-1].r});
    end
  end

  // stage 6: contact point, output register
  logic                hit_r;
  logic [2:0][NB-1:0]  onrm_r;
  logic [2:0][W-1:0]   opt_r;
  logic [W-1:0]        odep1_r, odep2_r;
  logic [REST_W-1:0]   orest_r;
  logic [2:0][W-1:0]   pt_nxt;
  logic [REST_W-1:0]   rest_nxt;

  always_comb begin
    logic signed [XW-1:0] ax, sh;
    for (int i = 0; i < 3; i++) begin
      ax = XW'($signed(st5_r.a[i]));
      sh = XW'($signed(prod_r[i]) >>> F);
      case (st5_r.func)
        FUNC_SPH_PLANE: pt_nxt[i] = sat_w(ax - sh);
        FUNC_BOX_SPH:   pt_nxt[i] = st5_r.q[i];
        default:        pt_nxt[i] = sat_w(ax + sh);
      endcase
    end
    rest_nxt = (st5_r.func == FUNC_BOX_SPH) ? rest_box_r : rest_sph_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= st5_r.hit;
      onrm_r  <= st5_r.hit ? nrm_r : '0;
      opt_r   <= st5_r.hit ? pt_nxt : '0;
      odep1_r <= st5_r.hit ? st5_r.dep1 : '0;
      odep2_r <= st5_r.hit ? st5_r.dep2 : '0;
      orest_r <= st5_r.hit ? rest_nxt : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      vsq_r      <= '0;
      v4_r       <= 1'b0;
      vdv_r      <= '0;
      v5_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v1_r       <= in_tvalid;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      vsq_r      <= {vsq_r[RTW-2:0], v3_r};
      v4_r       <= vsq_r[RTW-1];
      vdv_r      <= {vdv_r[QW-2:0], v4_r};
      v5_r       <= vdv_r[QW-1];
      out_tvalid <= v5_r;
    end
  end

  assign out_tuser = hit_r;
  assign out_tdata = OUTW'({orest_r, odep2_r, odep1_r, opt_r[2], opt_r[1], opt_r[0],
                            onrm_r[2], onrm_r[1], onrm_r[0]});

endmodule

/* verif/sphere_plane_box_contact_test_tb.sv */
module sphere_plane_box_contact_test_tb;
  import spbc_pkg::*;

  localparam int  WB        = 32;
  localparam int  FB        = 16;
  localparam int  NB        = FB + 2;
  localparam int  IN_W      = ((11*WB-1+7)/8)*8;
  localparam int  OUT_W     = ((3*NB+5*WB+8+7)/8)*8;
  localparam int  LATENCY   = WB + FB + 9;
  localparam int  LIMIT     = 400000;
  localparam int  N_RANDOM  = 1270;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [127:0] WMAX = 128'sh7fffffff;
  localparam logic signed [127:0] WMIN = -128'sh80000000;

  // field layout of out_tdata, lowest first
  localparam int FLD_LO [9] = '{0, 18, 36, 54, 86, 118, 150, 182, 214};
  localparam int FLD_W  [9] = '{18, 18, 18, 32, 32, 32, 32, 32, 8};

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] c [3];
    logic [30:0]        rad;
    logic signed [31:0] vb;
  } pair_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [1:0] in_tuser;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REST_W-1:0] cfg_data;

  logic [REST_W-1:0] rest_sph, rest_box;
  logic [OUT_W:0] contact_q [$];
  int errors, cycles;
  int send_idle_pct, recv_stall_pct;

  sphere_plane_box_contact_test #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sphere_plane_box_contact_test test failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat_word(logic signed [127:0] v);
    if (v > WMAX) return WMAX[31:0];
    if (v < WMIN) return WMIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic [33:0] vec_len(logic signed [127:0] d [3]);
    logic [127:0] s, cc;
    logic [33:0] r, c;
    s = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    r = '0;
    for (int k = 33; k >= 0; k--) begin
      c = r | (34'd1 << k);
      cc = {94'b0, c} * {94'b0, c};
      if (s >= cc) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [NB-1:0] unit_comp(logic signed [127:0] d, logic [33:0] len);
    logic [127:0] m, q;
    if (len == 0) return '0;
    m = d < 0 ? -d : d;
    q = (m << FB) / {94'b0, len};
    return d < 0 ? -q[NB-1:0] : q[NB-1:0];
  endfunction

  // returns {colliding, out_tdata}
  function automatic logic [OUT_W:0] predict_contact(pair_t it);
    logic signed [127:0] a [3], b [3], c [3], d [3], q [3];
    logic signed [127:0] r, vb, rsum, lenw, dot, perp, nw;
    logic signed [NB-1:0] n [3];
    logic signed [31:0] p [3], d1, d2;
    logic [7:0] rest;
    logic hit;
    logic [33:0] len;
    hit = 0; rest = '0; d1 = '0; d2 = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.a[i]; b[i] = it.b[i]; c[i] = it.c[i];
      n[i] = '0; p[i] = '0;
    end
    r  = $signed({97'b0, it.rad});
    vb = it.vb;
    case (it.kind)
      FUNC_SPH_SPH: begin
        rsum = r + vb;
        for (int i = 0; i < 3; i++) d[i] = b[i] - a[i];
        len = vec_len(d);
        lenw = $signed({94'b0, len});
        if (lenw <= rsum) begin
          hit = 1; rest = rest_sph;
          for (int i = 0; i < 3; i++) begin
            n[i] = unit_comp(d[i], len);
            nw = n[i];
            p[i] = sat_word(a[i] + ((nw * r) >>> FB));
          end
          d1 = sat_word(lenw - rsum);
          d2 = sat_word(rsum - lenw);
        end
      end
      FUNC_SPH_PLANE: begin
        dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        perp = (dot >>> FB) - vb;
        if (perp <= r) begin
          hit = 1; rest = rest_sph;
          for (int i = 0; i < 3; i++) begin
            if (b[i] > 65536) n[i] = 18'sd65536;
            else if (b[i] < -65536) n[i] = -18'sd65536;
            else n[i] = b[i][NB-1:0];
            p[i] = sat_word(a[i] - ((b[i] * r) >>> FB));
          end
          d1 = sat_word(r - perp);
        end
      end
      FUNC_BOX_SPH: begin
        for (int i = 0; i < 3; i++) begin
          q[i] = a[i] < b[i] ? b[i] : (a[i] > c[i] ? c[i] : a[i]);
          d[i] = a[i] - q[i];
        end
        len = vec_len(d);
        lenw = $signed({94'b0, len});
        if (lenw <= r) begin
          hit = 1; rest = rest_box;
          for (int i = 0; i < 3; i++) begin
            n[i] = unit_comp(d[i], len);
            p[i] = q[i][31:0];
          end
          d2 = sat_word(r - lenw);
        end
      end
      default: ;
    endcase
    return {hit, 2'b0, rest, d2, d1, p[2], p[1], p[0], n[2], n[1], n[0]};
  endfunction

  // result checker
  always @(posedge clk) begin
    logic [OUT_W:0] want;
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (contact_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", out_tdata);
      end else begin
        want = contact_q.pop_front();
        if (want[OUT_W] !== out_tuser) begin
          errors++;
          if (errors <= 10)
            $display("colliding: expected %b got %b", want[OUT_W], out_tuser);
        end
        for (int f = 0; f < 9; f++) begin
          if (((want[OUT_W-1:0] >> FLD_LO[f]) & ((256'd1 << FLD_W[f]) - 1)) !==
              ((out_tdata >> FLD_LO[f]) & ((256'd1 << FLD_W[f]) - 1))) begin
            errors++;
            if (errors <= 10)
              $display("field %0d: expected %h got %h", f,
                       (want[OUT_W-1:0] >> FLD_LO[f]) & ((256'd1 << FLD_W[f]) - 1),
                       (out_tdata >> FLD_LO[f]) & ((256'd1 << FLD_W[f]) - 1));
          end
        end
      end
    end
  end

  task automatic send_pair(pair_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {1'b0, it.vb, it.rad, it.c[2], it.c[1], it.c[0],
                  it.b[2], it.b[1], it.b[0], it.a[2], it.a[1], it.a[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    contact_q.insert(contact_q.size(), predict_contact(it));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REST_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_REST_SPH) rest_sph = val;
    else if (idx == REG_REST_BOX) rest_box = val;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_word();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic pair_t mk_pair(logic [1:0] kind, int ax, int ay, int az,
                                    int bx, int by, int bz, int cx, int cy, int cz,
                                    logic [30:0] rad, int vb);
    pair_t it;
    it.kind = kind;
    it.a = '{ax, ay, az}; it.b = '{bx, by, bz}; it.c = '{cx, cy, cz};
    it.rad = rad; it.vb = vb;
    return it;
  endfunction

  function automatic pair_t rnd_pair();
    pair_t it;
    int mode;
    mode = $urandom_range(0, 9);
    it.kind = (mode == 0) ? 2'($urandom) : 2'($urandom_range(0, 2));
    for (int i = 0; i < 3; i++) begin
      it.a[i] = rnd_word(); it.b[i] = rnd_word(); it.c[i] = rnd_word();
    end
    it.rad = 31'($urandom >> $urandom_range(1, 31));
    it.vb  = rnd_word();
    if (mode >= 2) begin
      // well-formed: nearby shapes so contact is common
      for (int i = 0; i < 3; i++) begin
        it.a[i] = $signed($urandom) >>> 12;
        case (it.kind)
          FUNC_SPH_SPH:   it.b[i] = it.a[i] + ($signed($urandom) >>> 15);
          FUNC_SPH_PLANE: it.b[i] = $signed($urandom) >>> 14;
          default: begin
            it.b[i] = it.a[i] + ($signed($urandom) >>> 14);
            it.c[i] = it.b[i] + 32'($urandom >> 14);
          end
        endcase
      end
      it.rad = 31'($urandom >> 14);
      it.vb  = (it.kind == FUNC_SPH_SPH) ? $signed(32'($urandom >> 14))
                                         : ($signed($urandom) >>> 8);
    end
    return it;
  endfunction

  task automatic test_edge_cases();
    // touching spheres, apart, coincident centres, full range, negative second radius
    send_pair(mk_pair(FUNC_SPH_SPH, 0, 0, 0, 65536*2, 0, 0, 0, 0, 0, 31'd65536, 65536));
    send_pair(mk_pair(FUNC_SPH_SPH, 0, 0, 0, 65536*3, 0, 0, 0, 0, 0, 31'd65536, 65536));
    send_pair(mk_pair(FUNC_SPH_SPH, 100, -5, 7, 100, -5, 7, 0, 0, 0, 31'd0, 0));
    send_pair(mk_pair(FUNC_SPH_SPH, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0,
                      31'h7fffffff, 32'h7fffffff));
    send_pair(mk_pair(FUNC_SPH_SPH, 0, 0, 0, 10, 0, 0, 0, 0, 0, 31'd5, -32'sd100));
    // plane through origin, normal +y, and saturating plane
    send_pair(mk_pair(FUNC_SPH_PLANE, 0, 65536/2, 0, 0, 65536, 0, 0, 0, 0, 31'd65536, 0));
    send_pair(mk_pair(FUNC_SPH_PLANE, 0, 65536*5, 0, 0, 65536, 0, 0, 0, 0, 31'd65536, 0));
    send_pair(mk_pair(FUNC_SPH_PLANE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0,
                      31'h7fffffff, 32'h80000000));
    send_pair(mk_pair(FUNC_SPH_PLANE, 1, 2, 3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      0, 0, 0, 31'h7fffffff, 32'h7fffffff));
    // box: centre inside, face contact, miss, inverted box, full range
    send_pair(mk_pair(FUNC_BOX_SPH, 0, 0, 0, -65536, -65536, -65536,
                      65536, 65536, 65536, 31'd65536, 0));
    send_pair(mk_pair(FUNC_BOX_SPH, 65536*2, 0, 0, -65536, -65536, -65536,
                      65536, 65536, 65536, 31'd65536*2, 0));
    send_pair(mk_pair(FUNC_BOX_SPH, 65536*9, 65536*9, 0, -65536, -65536, -65536,
                      65536, 65536, 65536, 31'd65536, 0));
    send_pair(mk_pair(FUNC_BOX_SPH, 0, 0, 0, 65536, 65536, 65536,
                      -65536, -65536, -65536, 31'd65536*4, 0));
    send_pair(mk_pair(FUNC_BOX_SPH, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
                      0, 32'h80000000, 32'h80000000, 0, 31'h7fffffff, 32'h7fffffff));
    // unused kind with everything set, then with everything clear
    send_pair(mk_pair(FUNC_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1, -1, 31'h7fffffff, -1));
    send_pair(mk_pair(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0, 0));
    drain();
  endtask

  task automatic test_register_settings();
    write_reg(REG_REST_SPH, 8'd0);
    write_reg(REG_REST_BOX, 8'd255);
    write_reg(REG_UNUSED, 8'hA5);
    send_pair(mk_pair(FUNC_SPH_SPH, 0, 0, 0, 1, 1, 1, 0, 0, 0, 31'd65536, 65536));
    send_pair(mk_pair(FUNC_BOX_SPH, 0, 0, 0, -1, -1, -1, 1, 1, 1, 31'd1, 0));
    send_pair(mk_pair(FUNC_SPH_PLANE, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 31'd1, 0));
    drain();
    write_reg(REG_REST_SPH, 8'd255);
    write_reg(REG_REST_BOX, 8'd0);
    send_pair(mk_pair(FUNC_SPH_SPH, 0, 0, 0, 1, 1, 1, 0, 0, 0, 31'd65536, 65536));
    send_pair(mk_pair(FUNC_BOX_SPH, 0, 0, 0, -1, -1, -1, 1, 1, 1, 31'd1, 0));
    drain();
  endtask

  task automatic test_random_traffic();
    int sidle [4] = '{0, 57, 0, 15};
    int rstall [4] = '{0, 0, 57, 15};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = sidle[ph];
      recv_stall_pct = rstall[ph];
      write_reg(REG_REST_SPH, 8'($urandom));
      write_reg(REG_REST_BOX, 8'($urandom));
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        send_pair(rnd_pair());
        // hold off once until the pipeline is empty
        if (ph == 1 && k == 100) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (contact_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    write_reg(REG_REST_SPH, REST_SPH_RST);
    write_reg(REG_REST_BOX, REST_BOX_RST);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tuser = '0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rest_sph = REST_SPH_RST;
    rest_box = REST_BOX_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_register_settings();
    test_random_traffic();
    if (errors == 0 && contact_q.size() == 0) begin
      $display("sphere_plane_box_contact_test test passed");
    end else begin
      $display("sphere_plane_box_contact_test test failed");
    end
    $finish;
  end

endmodule
